[sv/hmp_pkg.sv]
package hmp_pkg;

    localparam int WORD_BYTES = 8;
    localparam int WORD_W     = 64;
    localparam int LEN_W      = 61;
    localparam int VCNT_W     = 4;
    localparam int OFF_W      = 7;
    localparam int IDX_W      = 5;
    localparam int PAD_W      = 8;

    localparam logic [7:0]        PAD_MARK   = 8'h80;
    localparam logic [VCNT_W-1:0] FULL_WORD  = 4'd8;
    localparam logic [OFF_W-1:0]  MASK_64    = 7'h3F;
    localparam logic [OFF_W-1:0]  MASK_128   = 7'h7F;
    localparam logic [OFF_W-1:0]  LANE_ALIGN = 7'h78;
    localparam logic [OFF_W-1:0]  WORD_STEP  = 7'd8;
    localparam logic [8:0]        BSZ_64     = 9'd64;
    localparam logic [8:0]        BSZ_128    = 9'd128;
    localparam logic [8:0]        TAIL_MIN   = 9'd9;

    // controller -> datapath
    typedef struct packed {
        logic             pass;      // load a non-last word straight to the output
        logic             start;     // capture the last word and padding plan
        logic             emit;      // load padded word word_idx to the output
        logic [IDX_W-1:0] word_idx;
    } hmp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [IDX_W-1:0] last_idx;  // index of the final padded word
    } hmp_sts_t;

endpackage

[sv/hmp_ctrl.sv]
module hmp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             is_last,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output hmp_pkg::hmp_cmd_t cmd,
    input  hmp_pkg::hmp_sts_t sts
);
    import hmp_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_PAD  = 1'b1;

    logic             state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;
    logic             accept;

    always_comb
    begin
        out_free       = !out_valid_reg || !out_stall;
        in_stall       = (state_reg != ST_IDLE) || !out_free;
        accept         = in_valid && !in_stall;
        state_next     = state_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.word_idx   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_last)
                    begin
                        cmd.start  = 1'b1;
                        idx_next   = '0;
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        cmd.pass       = 1'b1;
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_PAD:
            begin
                if (out_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    if (idx_reg == sts.last_idx)
                        state_next = ST_IDLE;
                    else
                        idx_next = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[sv/hmp_dp.sv]
module hmp_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_wr_data,
    input  logic [hmp_pkg::WORD_W-1:0]  data_word,
    input  logic [hmp_pkg::VCNT_W-1:0]  valid_bytes,
    input  logic [hmp_pkg::LEN_W-1:0]   message_bytes,
    input  hmp_pkg::hmp_cmd_t           cmd,
    output hmp_pkg::hmp_sts_t           sts,
    output logic [hmp_pkg::WORD_W-1:0]  out_word,
    output logic                        end_of_block,
    output logic                        end_of_message,
    output logic [hmp_pkg::PAD_W-1:0]   pad_byte_count
);
    import hmp_pkg::*;

    // control state
    logic             bsel_reg;
    logic [OFF_W-1:0] boff_reg, boff_next;

    // captured last word and padding plan
    logic [WORD_W-1:0] data_reg;
    logic [VCNT_W-1:0] vcnt_reg;
    logic [WORD_W-1:0] bits_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [PAD_W-1:0]  pad_reg;
    logic [IDX_W-1:0]  last_idx_reg;

    // output register
    logic [WORD_W-1:0] word_reg;
    logic              eob_reg;
    logic              eom_reg;
    logic [PAD_W-1:0]  padcnt_reg;

    logic [OFF_W-1:0]  mask;
    logic [8:0]        bsz;
    logic [OFF_W-1:0]  off_in;
    logic [VCNT_W-1:0] vcnt_in;
    logic [8:0]        dpos;
    logic [8:0]        end_pos;
    logic [8:0]        pad_full;
    logic [8:0]        span;
    logic [IDX_W-1:0]  last_idx_in;
    logic [OFF_W-1:0]  pass_sum;
    logic [OFF_W-1:0]  emit_sum;
    logic [WORD_W-1:0] emit_word;
    logic              emit_final;
    logic              k_first;
    logic              k_second;

    always_comb
    begin
        mask   = bsel_reg ? MASK_128 : MASK_64;
        bsz    = bsel_reg ? BSZ_128 : BSZ_64;
        off_in = boff_reg & mask & LANE_ALIGN;
        vcnt_in = (valid_bytes > FULL_WORD) ? FULL_WORD : valid_bytes;
        dpos    = {2'b00, off_in} + {5'b00000, vcnt_in};
        end_pos = (dpos + TAIL_MIN <= bsz) ? bsz : {bsz[7:0], 1'b0};
        pad_full = end_pos - dpos;
        span     = end_pos - {2'b00, off_in};
        last_idx_in = span[IDX_W+2:3] - IDX_W'(1);

        pass_sum = off_in + WORD_STEP;
        emit_sum = off_reg + {cmd.word_idx[3:0], 3'b000} + WORD_STEP;

        // padded word: data lanes, then the 0x80 mark, zeros, length at the end
        k_first    = (cmd.word_idx == '0);
        k_second   = (cmd.word_idx == 5'd1);
        emit_final = (cmd.word_idx == last_idx_reg);
        emit_word  = '0;
        for (int j = 0; j < WORD_BYTES; j++)
        begin
            if (k_first && (4'(j) < vcnt_reg))
                emit_word[WORD_W-1-8*j -: 8] = data_reg[WORD_W-1-8*j -: 8];
            else if ((k_first && (4'(j) == vcnt_reg)) ||
                     (k_second && (vcnt_reg == FULL_WORD) && (j == 0)))
                emit_word[WORD_W-1-8*j -: 8] = PAD_MARK;
        end
        if (emit_final)
            emit_word = bits_reg;

        if (cmd.pass)
            boff_next = pass_sum & mask;
        else if (cmd.start)
            boff_next = '0;
        else
            boff_next = boff_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bsel_reg <= 1'b0;
            boff_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                bsel_reg <= cfg_wr_data;
            boff_reg <= boff_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            data_reg     <= data_word;
            vcnt_reg     <= vcnt_in;
            bits_reg     <= {message_bytes, 3'b000};
            off_reg      <= off_in;
            pad_reg      <= pad_full[PAD_W-1:0];
            last_idx_reg <= last_idx_in;
        end
        if (cmd.pass)
        begin
            word_reg   <= data_word;
            eob_reg    <= ((pass_sum & mask) == '0);
            eom_reg    <= 1'b0;
            padcnt_reg <= '0;
        end
        else if (cmd.emit)
        begin
            word_reg   <= emit_word;
            eob_reg    <= ((emit_sum & mask) == '0);
            eom_reg    <= emit_final;
            padcnt_reg <= emit_final ? pad_reg : '0;
        end
    end

    assign sts.last_idx    = last_idx_reg;
    assign out_word        = word_reg;
    assign end_of_block    = eob_reg;
    assign end_of_message  = eom_reg;
    assign pad_byte_count  = padcnt_reg;

endmodule

[sv/hash_message_padder.sv]
// Merkle-Damgard message padder with a 64-bit bit-length field (SHA-1/SHA-2/SM3
// style with 64-byte blocks, or with 128-byte blocks, picked by cfg_wr_data
// at a cfg_wr_en pulse; the user must pulse cfg_wr_en only while idle, and the
// block does not enforce this). Words are 8 bytes, first byte in bits 63:56.
// Rate: a message streams at one transfer per clock while out_stall stays low;
// the output register is refilled in the same cycle it is taken. The last word
// is captured and then the padder's sequencer emits its 2 to 18 result words,
// one per cycle while out_stall stays low, with in_stall held high.
// pad_byte_count is nonzero only on the end_of_message word.
module hash_message_padder (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       cfg_wr_en,
    input  logic                       cfg_wr_data,
    // input channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [hmp_pkg::WORD_W-1:0] data_word,
    input  logic [hmp_pkg::VCNT_W-1:0] valid_bytes,
    input  logic                       is_last,
    input  logic [hmp_pkg::LEN_W-1:0]  message_bytes,
    // output channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [hmp_pkg::WORD_W-1:0] out_word,
    output logic                       end_of_block,
    output logic                       end_of_message,
    output logic [hmp_pkg::PAD_W-1:0]  pad_byte_count
);
    import hmp_pkg::*;

    hmp_cmd_t cmd;
    hmp_sts_t sts;

    // sequencer: pass-through vs. padding run, output valid
    hmp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .is_last   (is_last),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // block offset, last-word capture, padded word build, output register
    hmp_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .data_word      (data_word),
        .valid_bytes    (valid_bytes),
        .message_bytes  (message_bytes),
        .cmd            (cmd),
        .sts            (sts),
        .out_word       (out_word),
        .end_of_block   (end_of_block),
        .end_of_message (end_of_message),
        .pad_byte_count (pad_byte_count)
    );

endmodule

[sv/hmp_checker.sv]
module hmp_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       is_last,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [hmp_pkg::WORD_W-1:0] out_word,
    input logic                       end_of_block,
    input logic                       end_of_message,
    input logic [hmp_pkg::PAD_W-1:0]  pad_byte_count
);
    import hmp_pkg::*;

    // a padded message always closes a hash block
    a_eom_closes_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_message |-> end_of_block)
        else $error("end_of_message without end_of_block");

    // pad count shows only on the message end, and covers mark plus length
    a_pad_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !end_of_message |-> pad_byte_count == '0)
        else $error("pad count on a non-final word");

    a_pad_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_message |-> pad_byte_count >= 8'd9 && pad_byte_count <= 8'd136)
        else $error("pad count out of range");

    // after a last-word transfer the input holds off while padding goes out
    a_last_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && is_last |=> in_stall)
        else $error("input taken during padding");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("stalled output changed");

endmodule

bind hash_message_padder hmp_checker u_hmp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .is_last        (is_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word),
    .end_of_block   (end_of_block),
    .end_of_message (end_of_message),
    .pad_byte_count (pad_byte_count)
);
